// File: rtl/htld_pkg.sv
// ----------------------------------------------------------------------------
// htld_pkg
// Shared types and constants for the Huffman tree load and decode core.
// ----------------------------------------------------------------------------
package htld_pkg;

    localparam int BYTE_W  = 8;
    localparam int PAD_W   = 3;
    localparam int TLEN_W  = 13;
    localparam int BITS_W  = 4;

    localparam logic [BYTE_W-1:0] CH_INTERNAL = 8'h2A;  // '*'
    localparam logic [BYTE_W-1:0] CH_ESCAPE   = 8'h5C;  // backslash
    localparam logic [TLEN_W-1:0] TLEN_MAX    = 13'h1FFF;

    // input commands
    localparam logic [1:0] CMD_HDR1 = 2'd0;
    localparam logic [1:0] CMD_HDR2 = 2'd1;
    localparam logic [1:0] CMD_TREE = 2'd2;
    localparam logic [1:0] CMD_DATA = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LEN    = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;
    localparam logic [1:0] ST_NOTREE = 2'd3;

    typedef enum logic [1:0] {
        PH_HDR1,
        PH_HDR2,
        PH_TREE,
        PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD,
        S_POP,
        S_PUSH,
        S_EVAL,
        S_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       accept;
        logic       tbs_inc;
        logic       hdr1_load;
        logic       hdr2_load;
        logic       esc_set;
        logic       esc_clr;
        logic       leaf_latch;
        logic       node_wr_new;
        logic       node_wr_right;
        logic       stack_pop;
        logic       stack_push;
        logic       nf_inc;
        logic       walk_init;
        logic       walk_step;
        logic       walk_enter;
        logic       out_final;
        logic       phase_wr;
        t_phase     phase_val;
        logic       status_wr;
        logic [1:0] status_val;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        t_phase     phase;
        logic [1:0] cmd;
        logic       fin;
        logic       esc;
        logic       byte_is_esc;
        logic       add_leaf;
        logic       nf_full;
        logic       nf_zero;
        logic       prev_leaf;
        logic       sp_zero;
        logic       sp_full;
        logic       tbs_eq;
        logic       tbs_ge;
        logic       ev_leaf;
        logic       pend_valid;
        logic       out_busy;
        logic       last_bit;
    } t_sts;

endpackage

// File: rtl/huffman_tree_load_and_decode_core.sv
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode_core
// Byte-stream Huffman decoder: header, pre-order tree load, MSB-first decode.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------
//  input   | in        | i_valid / o_stall | i_command, i_byte_value, i_final_byte
//  output  | out       | o_valid / i_stall | o_symbol, o_symbol_valid, o_run_end,
//          |           |                   | o_tree_ready, o_status
//
//  Header, rejected and escape-marker bytes pass EXEC and RESULT. A tree byte
//  adding a node passes EXEC, ADD (one node RAM write), PUSH and RESULT, with
//  POP after ADD to link a right child (stack RAM read, second node write);
//  a full node table sends ADD to RESULT. A data byte walks its nbits (8, or
//  8 minus final-byte padding) in EVAL, one chained node RAM read per bit.
//  i_rst_n is synchronous; node and stack RAMs are not cleared.
//  One item is worked at a time; o_stall is high while an item is in flight.
//  A stalled output transfer holds the walk only when a new symbol needs
//  the output register.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode_core #(
    parameter int NODE_COUNT  = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_byte_value,
    input  logic       i_final_byte,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_symbol,
    output logic       o_symbol_valid,
    output logic       o_run_end,
    output logic       o_tree_ready,
    output logic [1:0] o_status
);

    htld_pkg::t_ctl ctl;
    htld_pkg::t_sts sts;
    logic           busy;

    // the input transfer completes only while the sequencer is idle
    assign o_stall = busy;

    htld_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_sts     (sts),
        .o_ctl     (ctl),
        .o_busy    (busy)
    );

    // node table, pending stack, walker and output register
    htld_datapath #(
        .NODE_COUNT  (NODE_COUNT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_command      (i_command),
        .i_byte_value   (i_byte_value),
        .i_final_byte   (i_final_byte),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_symbol       (o_symbol),
        .o_symbol_valid (o_symbol_valid),
        .o_run_end      (o_run_end),
        .o_tree_ready   (o_tree_ready),
        .o_status       (o_status)
    );

endmodule

// File: rtl/htld_ram.sv
// ----------------------------------------------------------------------------
// htld_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module htld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/htld_datapath.sv
// ----------------------------------------------------------------------------
// htld_datapath
// Stream registers, tree builder storage, tree walker and output register.
// ----------------------------------------------------------------------------
module htld_datapath #(
    parameter int NODE_COUNT  = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  htld_pkg::t_ctl      i_ctl,
    output htld_pkg::t_sts      o_sts,
    input  logic [1:0]          i_command,
    input  logic [7:0]          i_byte_value,
    input  logic                i_final_byte,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [7:0]          o_symbol,
    output logic                o_symbol_valid,
    output logic                o_run_end,
    output logic                o_tree_ready,
    output logic [1:0]          o_status
);

    localparam int NW  = $clog2(NODE_COUNT);
    localparam int NFW = $clog2(NODE_COUNT + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int EW  = htld_pkg::BYTE_W + 1 + NW;

    function automatic logic [NW-1:0] next_idx(input logic [NW-1:0] idx);
        logic [NW-1:0] res;
        if (idx == NW'(NODE_COUNT - 1)) begin
            res = '0;
        end else begin
            res = idx + NW'(1);
        end
        return res;
    endfunction

    logic [1:0]                   r_cmd;
    logic [7:0]                   r_byte;
    logic                         r_fin;
    logic [7:0]                   r_shift;
    logic [htld_pkg::PAD_W-1:0]   r_pad;
    logic [htld_pkg::TLEN_W-1:0]  r_tlen;
    logic [htld_pkg::TLEN_W-1:0]  r_tbs;
    logic [SPW-1:0]               r_sp;
    logic [NFW-1:0]               r_nf;
    logic                         r_esc;
    logic                         r_prev_leaf;
    logic                         r_add_leaf;
    logic                         r_root_leaf;
    logic [7:0]                   r_root_sym;
    logic [NW-1:0]                r_root_right;
    logic [NW-1:0]                r_walk;
    logic [NW-1:0]                r_walk_right;
    logic [htld_pkg::BITS_W-1:0]  r_bits;
    logic [7:0]                   r_pend_sym;
    logic                         r_pend_valid;
    htld_pkg::t_phase             r_phase;
    logic [1:0]                   r_status;
    logic                         r_o_valid;
    logic [7:0]                   r_o_symbol;
    logic                         r_o_symbol_valid;
    logic                         r_o_run_end;
    logic                         r_o_tree_ready;
    logic [1:0]                   r_o_status;

    // node RAM
    logic            node_we;
    logic [NW-1:0]   node_waddr;
    logic [EW-1:0]   node_wdata;
    logic            node_re;
    logic [NW-1:0]   node_raddr;
    logic [EW-1:0]   node_rdata;
    // stack RAM
    logic [NW-1:0]   stack_rdata;

    logic [7:0]      rd_sym;
    logic            rd_leaf;
    logic [NW-1:0]   rd_right;
    logic [NW-1:0]   child_cur;
    logic            ev_leaf;
    logic [7:0]      ev_sym;
    logic [NW-1:0]   ev_walk;
    logic [NW-1:0]   ev_right;
    logic [NW-1:0]   child_next;
    logic            last_bit;
    logic            out_busy;
    logic            load_pend;

    assign rd_sym   = node_rdata[EW-1 -: 8];
    assign rd_leaf  = node_rdata[NW];
    assign rd_right = node_rdata[NW-1:0];

    // walker: current bit is r_shift[7]
    assign child_cur  = r_shift[7] ? r_walk_right : next_idx(r_walk);
    assign ev_leaf    = r_root_leaf | rd_leaf;
    assign ev_sym     = r_root_leaf ? r_root_sym : rd_sym;
    assign ev_walk    = ev_leaf ? '0 : child_cur;
    assign ev_right   = ev_leaf ? r_root_right : rd_right;
    assign child_next = r_shift[6] ? ev_right : next_idx(ev_walk);
    assign last_bit   = (r_bits == htld_pkg::BITS_W'(1));

    assign out_busy  = r_o_valid & i_stall;
    assign load_pend = i_ctl.walk_step & ev_leaf & r_pend_valid;

    assign node_we    = i_ctl.node_wr_new | i_ctl.node_wr_right;
    assign node_waddr = i_ctl.node_wr_right ? stack_rdata : r_nf[NW-1:0];
    assign node_wdata = i_ctl.node_wr_right ?
                        {htld_pkg::CH_INTERNAL, 1'b0, r_nf[NW-1:0]} :
                        {r_byte, r_add_leaf, {NW{1'b0}}};
    assign node_re    = i_ctl.walk_init | (i_ctl.walk_step & ~last_bit);
    assign node_raddr = i_ctl.walk_init ? child_cur : child_next;

    htld_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    htld_ram #(
        .WIDTH (NW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.stack_push),
        .i_waddr (r_sp[SAW-1:0]),
        .i_wdata (r_nf[NW-1:0]),
        .i_re    (i_ctl.stack_pop),
        .i_raddr (SAW'(r_sp - SPW'(1))),
        .o_rdata (stack_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= htld_pkg::PH_HDR1;
            r_sp      <= '0;
            r_nf      <= '0;
            r_esc     <= 1'b0;
            r_tlen    <= '0;
            r_tbs     <= '0;
            r_pad     <= '0;
            r_walk    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_ctl.phase_wr) begin
                r_phase <= i_ctl.phase_val;
            end
            if (i_ctl.hdr1_load) begin
                r_pad  <= r_byte[7:5];
                r_tlen <= {r_byte[4:0], 8'h00};
            end
            if (i_ctl.hdr2_load) begin
                r_tlen[7:0] <= r_byte;
                r_tbs       <= '0;
                r_sp        <= '0;
                r_nf        <= '0;
                r_esc       <= 1'b0;
                r_walk      <= '0;
            end
            if (i_ctl.tbs_inc && r_tbs != htld_pkg::TLEN_MAX) begin
                r_tbs <= r_tbs + htld_pkg::TLEN_W'(1);
            end
            if (i_ctl.esc_set) begin
                r_esc <= 1'b1;
            end
            if (i_ctl.esc_clr) begin
                r_esc <= 1'b0;
            end
            if (i_ctl.stack_pop) begin
                r_sp <= r_sp - SPW'(1);
            end
            if (i_ctl.stack_push) begin
                r_sp <= r_sp + SPW'(1);
            end
            if (i_ctl.nf_inc) begin
                r_nf <= r_nf + NFW'(1);
            end
            if (i_ctl.walk_enter) begin
                r_walk <= '0;
            end
            if (i_ctl.walk_step) begin
                r_walk <= (last_bit && r_fin) ? '0 : ev_walk;
            end
            if (load_pend || i_ctl.out_final) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd        <= i_command;
            r_byte       <= i_byte_value;
            r_fin        <= i_final_byte;
            r_shift      <= i_byte_value;
            r_pend_valid <= 1'b0;
        end
        if (i_ctl.status_wr) begin
            r_status <= i_ctl.status_val;
        end
        if (i_ctl.leaf_latch) begin
            r_add_leaf <= r_esc | (r_byte != htld_pkg::CH_INTERNAL);
        end
        if (i_ctl.node_wr_new) begin
            r_prev_leaf <= r_add_leaf;
            if (r_nf == '0) begin
                r_root_leaf  <= r_add_leaf;
                r_root_sym   <= r_byte;
                r_root_right <= '0;
            end
        end
        if (i_ctl.node_wr_right && stack_rdata == '0) begin
            r_root_right <= r_nf[NW-1:0];
        end
        if (i_ctl.walk_enter) begin
            r_walk_right <= r_root_right;
        end
        if (i_ctl.walk_init) begin
            r_bits <= r_fin ? (htld_pkg::BITS_W'(8) - htld_pkg::BITS_W'(r_pad))
                            : htld_pkg::BITS_W'(8);
        end
        if (i_ctl.walk_step) begin
            r_shift      <= {r_shift[6:0], 1'b0};
            r_bits       <= r_bits - htld_pkg::BITS_W'(1);
            r_walk_right <= (last_bit && r_fin) ? r_root_right : ev_right;
            if (ev_leaf) begin
                r_pend_sym   <= ev_sym;
                r_pend_valid <= 1'b1;
            end
        end
        if (load_pend) begin
            r_o_symbol       <= r_pend_sym;
            r_o_symbol_valid <= 1'b1;
            r_o_run_end      <= 1'b0;
            r_o_tree_ready   <= (r_phase == htld_pkg::PH_DATA);
            r_o_status       <= r_status;
        end else if (i_ctl.out_final) begin
            r_o_symbol       <= r_pend_valid ? r_pend_sym : 8'h00;
            r_o_symbol_valid <= r_pend_valid;
            r_o_run_end      <= 1'b1;
            r_o_tree_ready   <= (r_phase == htld_pkg::PH_DATA);
            r_o_status       <= r_status;
        end
    end

    always_comb begin
        o_sts.phase       = r_phase;
        o_sts.cmd         = r_cmd;
        o_sts.fin         = r_fin;
        o_sts.esc         = r_esc;
        o_sts.byte_is_esc = (r_byte == htld_pkg::CH_ESCAPE);
        o_sts.add_leaf    = r_add_leaf;
        o_sts.nf_full     = (r_nf >= NFW'(NODE_COUNT));
        o_sts.nf_zero     = (r_nf == '0);
        o_sts.prev_leaf   = r_prev_leaf;
        o_sts.sp_zero     = (r_sp == '0);
        o_sts.sp_full     = (r_sp >= SPW'(STACK_DEPTH));
        o_sts.tbs_eq      = (r_tbs == r_tlen);
        o_sts.tbs_ge      = (r_tbs >= r_tlen);
        o_sts.ev_leaf     = ev_leaf;
        o_sts.pend_valid  = r_pend_valid;
        o_sts.out_busy    = out_busy;
        o_sts.last_bit    = last_bit;
    end

    assign o_valid        = r_o_valid;
    assign o_symbol       = r_o_symbol;
    assign o_symbol_valid = r_o_symbol_valid;
    assign o_run_end      = r_o_run_end;
    assign o_tree_ready   = r_o_tree_ready;
    assign o_status       = r_o_status;

endmodule

// File: rtl/htld_ctrl.sv
// ----------------------------------------------------------------------------
// htld_ctrl
// Sequencer for header, tree build and data walk steps.
// ----------------------------------------------------------------------------
module htld_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_command,
    input  htld_pkg::t_sts  i_sts,
    output htld_pkg::t_ctl  o_ctl,
    output logic            o_busy
);

    htld_pkg::t_state r_state;
    htld_pkg::t_state n_state;
    logic             eval_hold;
    logic             need_pop;

    assign eval_hold = i_sts.ev_leaf & i_sts.pend_valid & i_sts.out_busy;
    assign need_pop  = ~i_sts.nf_zero & i_sts.prev_leaf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htld_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            htld_pkg::S_IDLE: begin
                if (i_valid) n_state = htld_pkg::S_EXEC;
            end
            htld_pkg::S_EXEC: begin
                n_state = htld_pkg::S_RESULT;
                if (i_sts.cmd == htld_pkg::CMD_TREE && i_sts.phase == htld_pkg::PH_TREE &&
                    (i_sts.esc || !i_sts.byte_is_esc)) begin
                    n_state = htld_pkg::S_ADD;
                end
                if (i_sts.cmd == htld_pkg::CMD_DATA && i_sts.phase == htld_pkg::PH_DATA) begin
                    n_state = htld_pkg::S_EVAL;
                end
            end
            htld_pkg::S_ADD: begin
                if (i_sts.nf_full) begin
                    n_state = htld_pkg::S_RESULT;
                end else if (need_pop) begin
                    n_state = i_sts.sp_zero ? htld_pkg::S_RESULT : htld_pkg::S_POP;
                end else begin
                    n_state = htld_pkg::S_PUSH;
                end
            end
            htld_pkg::S_POP:  n_state = htld_pkg::S_PUSH;
            htld_pkg::S_PUSH: n_state = htld_pkg::S_RESULT;
            htld_pkg::S_EVAL: begin
                if (!eval_hold && i_sts.last_bit) n_state = htld_pkg::S_RESULT;
            end
            htld_pkg::S_RESULT: begin
                if (!i_sts.out_busy) n_state = htld_pkg::S_IDLE;
            end
            default: n_state = htld_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl  = '0;
        o_busy = (r_state != htld_pkg::S_IDLE);
        unique case (r_state)
            htld_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_ctl.accept  = 1'b1;
                    o_ctl.tbs_inc = (i_command == htld_pkg::CMD_TREE) &&
                                    (i_sts.phase == htld_pkg::PH_TREE);
                end
            end
            htld_pkg::S_EXEC: begin
                o_ctl.status_wr  = 1'b1;
                o_ctl.status_val = htld_pkg::ST_OK;
                unique case (i_sts.cmd)
                    htld_pkg::CMD_HDR1: begin
                        o_ctl.hdr1_load = 1'b1;
                        o_ctl.phase_wr  = 1'b1;
                        o_ctl.phase_val = htld_pkg::PH_HDR2;
                    end
                    htld_pkg::CMD_HDR2: begin
                        if (i_sts.phase == htld_pkg::PH_HDR2) begin
                            o_ctl.hdr2_load = 1'b1;
                            o_ctl.phase_wr  = 1'b1;
                            o_ctl.phase_val = htld_pkg::PH_TREE;
                        end else begin
                            o_ctl.status_val = htld_pkg::ST_BAD;
                        end
                    end
                    htld_pkg::CMD_TREE: begin
                        if (i_sts.phase != htld_pkg::PH_TREE) begin
                            o_ctl.status_val = htld_pkg::ST_BAD;
                        end else if (i_sts.esc) begin
                            o_ctl.esc_clr    = 1'b1;
                            o_ctl.leaf_latch = 1'b1;
                        end else if (i_sts.byte_is_esc) begin
                            o_ctl.esc_set = 1'b1;
                            if (i_sts.tbs_ge) begin
                                o_ctl.phase_wr   = 1'b1;
                                o_ctl.phase_val  = htld_pkg::PH_HDR1;
                                o_ctl.status_val = htld_pkg::ST_LEN;
                            end
                        end else begin
                            o_ctl.leaf_latch = 1'b1;
                        end
                    end
                    htld_pkg::CMD_DATA: begin
                        if (i_sts.phase != htld_pkg::PH_DATA) begin
                            o_ctl.status_val = htld_pkg::ST_NOTREE;
                        end else begin
                            o_ctl.walk_init = 1'b1;
                            if (i_sts.fin) begin
                                o_ctl.phase_wr  = 1'b1;
                                o_ctl.phase_val = htld_pkg::PH_HDR1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            htld_pkg::S_ADD: begin
                if (i_sts.nf_full || (need_pop && i_sts.sp_zero)) begin
                    o_ctl.phase_wr   = 1'b1;
                    o_ctl.phase_val  = htld_pkg::PH_HDR1;
                    o_ctl.status_wr  = 1'b1;
                    o_ctl.status_val = htld_pkg::ST_BAD;
                end
                if (!i_sts.nf_full) begin
                    o_ctl.node_wr_new = 1'b1;
                    o_ctl.stack_pop   = need_pop & ~i_sts.sp_zero;
                end
            end
            htld_pkg::S_POP: begin
                o_ctl.node_wr_right = 1'b1;
            end
            htld_pkg::S_PUSH: begin
                o_ctl.nf_inc    = 1'b1;
                o_ctl.status_wr = 1'b1;
                if (!i_sts.add_leaf && i_sts.sp_full) begin
                    o_ctl.phase_wr   = 1'b1;
                    o_ctl.phase_val  = htld_pkg::PH_HDR1;
                    o_ctl.status_val = htld_pkg::ST_BAD;
                end else if (i_sts.add_leaf && i_sts.sp_zero) begin
                    // tree complete
                    o_ctl.phase_wr = 1'b1;
                    if (i_sts.tbs_eq) begin
                        o_ctl.phase_val  = htld_pkg::PH_DATA;
                        o_ctl.walk_enter = 1'b1;
                        o_ctl.status_val = htld_pkg::ST_OK;
                    end else begin
                        o_ctl.phase_val  = htld_pkg::PH_HDR1;
                        o_ctl.status_val = htld_pkg::ST_LEN;
                    end
                end else begin
                    o_ctl.stack_push = ~i_sts.add_leaf;
                    if (i_sts.tbs_ge) begin
                        o_ctl.phase_wr   = 1'b1;
                        o_ctl.phase_val  = htld_pkg::PH_HDR1;
                        o_ctl.status_val = htld_pkg::ST_LEN;
                    end else begin
                        o_ctl.status_val = htld_pkg::ST_OK;
                    end
                end
            end
            htld_pkg::S_EVAL: begin
                o_ctl.walk_step = ~eval_hold;
            end
            htld_pkg::S_RESULT: begin
                o_ctl.out_final = ~i_sts.out_busy;
            end
            default: ;
        endcase
    end

endmodule

// File: tb/huffman_tree_load_and_decode_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode_core_tb
// Self-checking bench: directed stream table, tree overflow runs, then random
// well-formed streams mixed with noise, checked against a behavioral decoder.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode_core_tb;

    localparam int NODES   = 512;
    localparam int DEPTH   = 256;
    localparam int N_ROWS  = 30;
    localparam int N_ITEMS = 200;

    // one decoded result as seen on the output channel
    typedef struct {
        logic [7:0] sym;
        logic       sv;
        logic       re;
        logic       rdy;
        logic [1:0] st;
    } sym_res_t;

    // directed table row; typed rows carry their single expected result
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] val;
        logic       fin;
        bit         typed;
        logic       rdy;
        logic [1:0] st;
    } dir_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_command = htld_pkg::CMD_HDR1;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_symbol;
    logic       o_symbol_valid;
    logic       o_run_end;
    logic       o_tree_ready;
    logic [1:0] o_status;

    huffman_tree_load_and_decode_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_byte_value   (i_byte_value),
        .i_final_byte   (i_final_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_symbol       (o_symbol),
        .o_symbol_valid (o_symbol_valid),
        .o_run_end      (o_run_end),
        .o_tree_ready   (o_tree_ready),
        .o_status       (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #25ms;
        $display("FAIL huffman_tree_load_and_decode_core");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Decoder shadow state: node table, pending right-child stack, header.
    // ------------------------------------------------------------------------
    bit   [7:0]  nd_sym   [NODES];
    bit          nd_leaf  [NODES];
    bit   [8:0]  nd_right [NODES];
    bit   [8:0]  pend_stk [DEPTH];
    int          pend_sp   = 0;
    int          free_node = 0;
    bit          esc_armed = 0;
    logic [12:0] tree_len  = '0;
    int          tree_seen = 0;
    logic [2:0]  pad_bits  = '0;
    int          walk_at   = 0;
    htld_pkg::t_phase dec_phase = htld_pkg::PH_HDR1;

    sym_res_t    sym_exp_q[$];
    int          mismatches = 0;

    // append one node in pre-order; the left child is always the next node
    function automatic logic [1:0] place_node(logic [7:0] s, bit lf, output bit done);
        int n;
        n    = free_node;
        done = 0;
        if (n >= NODES) return htld_pkg::ST_BAD;
        nd_sym[n]   = s;
        nd_leaf[n]  = lf;
        nd_right[n] = '0;
        // a node after a leaf is the right child of the newest open internal
        if (n > 0 && nd_leaf[n-1]) begin
            if (pend_sp == 0) return htld_pkg::ST_BAD;
            pend_sp--;
            nd_right[pend_stk[pend_sp]] = n[8:0];
        end
        free_node = n + 1;
        if (!lf) begin
            if (pend_sp >= DEPTH) return htld_pkg::ST_BAD;
            pend_stk[pend_sp] = n[8:0];
            pend_sp++;
        end else if (pend_sp == 0) begin
            done = 1;
        end
        return htld_pkg::ST_OK;
    endfunction

    // advance the shadow decoder by one transfer, queue the symbols it yields
    function automatic void decode_transfer(logic [1:0] c, logic [7:0] b, logic f);
        logic [1:0] st;
        logic [7:0] syms[$];
        bit         done;
        int         nb;
        int         ch;
        sym_res_t   r;
        st = htld_pkg::ST_OK;
        case (c)
            htld_pkg::CMD_HDR1: begin
                pad_bits  = b[7:5];
                tree_len  = {b[4:0], 8'h00};
                dec_phase = htld_pkg::PH_HDR2;
            end
            htld_pkg::CMD_HDR2: begin
                if (dec_phase == htld_pkg::PH_HDR2) begin
                    tree_len[7:0] = b;
                    tree_seen = 0;
                    pend_sp   = 0;
                    free_node = 0;
                    esc_armed = 0;
                    walk_at   = 0;
                    dec_phase = htld_pkg::PH_TREE;
                end else begin
                    st = htld_pkg::ST_BAD;
                end
            end
            htld_pkg::CMD_TREE: begin
                if (dec_phase != htld_pkg::PH_TREE) begin
                    st = htld_pkg::ST_BAD;
                end else begin
                    done = 0;
                    if (tree_seen < int'(htld_pkg::TLEN_MAX)) tree_seen++;
                    if (esc_armed) begin
                        esc_armed = 0;
                        st = place_node(b, 1'b1, done);
                    end else if (b == htld_pkg::CH_ESCAPE) begin
                        esc_armed = 1;
                    end else begin
                        st = place_node(b, b != htld_pkg::CH_INTERNAL, done);
                    end
                    if (st != htld_pkg::ST_OK) begin
                        dec_phase = htld_pkg::PH_HDR1;
                    end else if (done) begin
                        if (tree_seen == int'(tree_len)) begin
                            dec_phase = htld_pkg::PH_DATA;
                            walk_at   = 0;
                        end else begin
                            dec_phase = htld_pkg::PH_HDR1;
                            st = htld_pkg::ST_LEN;
                        end
                    end else if (tree_seen >= int'(tree_len)) begin
                        // length used up with the tree still open
                        dec_phase = htld_pkg::PH_HDR1;
                        st = htld_pkg::ST_LEN;
                    end
                end
            end
            default: begin
                if (dec_phase != htld_pkg::PH_DATA) begin
                    st = htld_pkg::ST_NOTREE;
                end else begin
                    nb = f ? 8 - int'(pad_bits) : 8;
                    for (int i = 0; i < nb; i++) begin
                        if (nd_leaf[0]) begin
                            // single-leaf tree: every bit is the root symbol
                            syms.push_back(nd_sym[0]);
                            walk_at = 0;
                        end else begin
                            ch = b[7-i] ? int'(nd_right[walk_at]) : walk_at + 1;
                            ch = ch % NODES;
                            if (nd_leaf[ch]) begin
                                syms.push_back(nd_sym[ch]);
                                walk_at = 0;
                            end else begin
                                walk_at = ch;
                            end
                        end
                    end
                    if (f) begin
                        walk_at   = 0;
                        dec_phase = htld_pkg::PH_HDR1;
                    end
                end
            end
        endcase
        r.rdy = (dec_phase == htld_pkg::PH_DATA);
        r.st  = st;
        if (syms.size() == 0) begin
            r.sym = '0; r.sv = 1'b0; r.re = 1'b1;
            sym_exp_q.push_back(r);
        end else begin
            foreach (syms[k]) begin
                r.sym = syms[k];
                r.sv  = 1'b1;
                r.re  = (k == syms.size() - 1);
                sym_exp_q.push_back(r);
            end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: checks each transfer, stalls on its own pattern.
    // ------------------------------------------------------------------------
    bit long_hold_req = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int out_cyc = 0;

    always @(posedge i_clk) begin
        sym_res_t w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (sym_exp_q.size() == 0) begin
                    report_mismatch("unexpected transfer", o_symbol, 0);
                end else begin
                    w = sym_exp_q.pop_front();
                    if (o_symbol !== w.sym)       report_mismatch("symbol", o_symbol, w.sym);
                    if (o_symbol_valid !== w.sv)
                        report_mismatch("symbol_valid", o_symbol_valid, w.sv);
                    if (o_run_end !== w.re)       report_mismatch("run_end", o_run_end, w.re);
                    if (o_tree_ready !== w.rdy)
                        report_mismatch("tree_ready", o_tree_ready, w.rdy);
                    if (o_status !== w.st)        report_mismatch("status", o_status, w.st);
                end
            end
            out_cyc++;
            if (out_cyc % 64 == 0) stall_mode = $urandom_range(0, 2);
            if (long_hold_req) begin
                long_hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 1) == 1);
                    default: i_stall <= (out_cyc % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side: bursts of transfers with random gaps.
    // ------------------------------------------------------------------------
    int burst_left = 0;

    // o_stall only moves at rising edges, so it is sampled mid-cycle
    task automatic offer(logic [1:0] c, logic [7:0] b, logic f);
        bit acc;
        i_valid      <= 1'b1;
        i_command    <= c;
        i_byte_value <= b;
        i_final_byte <= f;
        do begin
            @(negedge i_clk);
            acc = !o_stall;
            @(posedge i_clk);
        end while (!acc);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            // some bursts are long enough to run back-to-back for a while
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send(logic [1:0] c, logic [7:0] b, logic f);
        offer(c, b, f);
        decode_transfer(c, b, f);
        pace();
    endtask

    task automatic drain_all();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sym_exp_q.size() != 0) @(posedge i_clk);
    endtask

    // random tree in pre-order, leaf symbols escaped where needed
    logic [7:0] tree_q[$];

    function automatic void build_tree();
        int need;
        int nodes;
        int maxn;
        logic [7:0] s;
        need  = 1;
        nodes = 0;
        maxn  = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(5, 30);
        tree_q.delete();
        while (need > 0) begin
            if (nodes < maxn && $urandom_range(0, 1) == 1) begin
                tree_q.push_back(htld_pkg::CH_INTERNAL);
                need++;
            end else begin
                s = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 7) == 0)
                    s = $urandom_range(0, 1) ? htld_pkg::CH_INTERNAL : htld_pkg::CH_ESCAPE;
                if (s == htld_pkg::CH_INTERNAL || s == htld_pkg::CH_ESCAPE ||
                    $urandom_range(0, 15) == 0)
                    tree_q.push_back(htld_pkg::CH_ESCAPE);
                tree_q.push_back(s);
                need--;
            end
            nodes++;
        end
    endfunction

    dir_row_t dir_rows [N_ROWS];

    initial begin
        int kind;
        int n_sent;
        int len;
        int n_data;
        int cut;
        int streams;
        logic [2:0] pad;
        int mark;
        sym_res_t tr;

        dir_rows = '{
            // nothing loaded yet: data, header two and tree bytes all refused
            '{htld_pkg::CMD_DATA, 8'h00, 1'b0, 1'b1, 1'b0, htld_pkg::ST_NOTREE},
            '{htld_pkg::CMD_HDR2, 8'h00, 1'b0, 1'b1, 1'b0, htld_pkg::ST_BAD},
            '{htld_pkg::CMD_TREE, 8'h41, 1'b0, 1'b1, 1'b0, htld_pkg::ST_BAD},
            // pad 5, tree "*AB"
            '{htld_pkg::CMD_HDR1, 8'hA0, 1'b0, 1'b1, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_HDR2, 8'h03, 1'b0, 1'b1, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h2A, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h41, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h42, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_DATA, 8'h00, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_DATA, 8'hA5, 1'b1, 1'b0, 1'b0, htld_pkg::ST_OK},
            // single-leaf tree, no padding
            '{htld_pkg::CMD_HDR1, 8'h00, 1'b0, 1'b1, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_HDR2, 8'h01, 1'b0, 1'b1, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h5A, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_DATA, 8'h5A, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_DATA, 8'hC3, 1'b1, 1'b0, 1'b0, htld_pkg::ST_OK},
            // escaped leaves '*' and backslash, pad 7 leaves one bit
            '{htld_pkg::CMD_HDR1, 8'hE0, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_HDR2, 8'h05, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h2A, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h5C, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h2A, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h5C, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h5C, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_DATA, 8'h80, 1'b1, 1'b0, 1'b0, htld_pkg::ST_OK},
            // tree done before its length
            '{htld_pkg::CMD_HDR1, 8'h00, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_HDR2, 8'h05, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h51, 1'b0, 1'b1, 1'b0, htld_pkg::ST_LEN},
            // length used up with the tree still open
            '{htld_pkg::CMD_HDR1, 8'h00, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_HDR2, 8'h01, 1'b0, 1'b0, 1'b0, htld_pkg::ST_OK},
            '{htld_pkg::CMD_TREE, 8'h2A, 1'b0, 1'b1, 1'b0, htld_pkg::ST_LEN}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            offer(dir_rows[r].cmd, dir_rows[r].val, dir_rows[r].fin);
            mark = sym_exp_q.size();
            decode_transfer(dir_rows[r].cmd, dir_rows[r].val, dir_rows[r].fin);
            if (dir_rows[r].typed) begin
                while (sym_exp_q.size() > mark) void'(sym_exp_q.pop_back());
                tr.sym = '0; tr.sv = 1'b0; tr.re = 1'b1;
                tr.rdy = dir_rows[r].rdy;
                tr.st  = dir_rows[r].st;
                sym_exp_q.push_back(tr);
            end
            pace();
        end

        // sender waits for the output side to empty completely
        drain_all();

        // stack overflow: 257 open internal nodes
        send(htld_pkg::CMD_HDR1, 8'h1F, 1'b0);
        send(htld_pkg::CMD_HDR2, 8'hFF, 1'b0);
        repeat (DEPTH + 1) send(htld_pkg::CMD_TREE, htld_pkg::CH_INTERNAL, 1'b0);

        // header restart in the middle of a tree
        send(htld_pkg::CMD_HDR1, 8'h00, 1'b0);
        send(htld_pkg::CMD_HDR2, 8'h09, 1'b0);
        send(htld_pkg::CMD_TREE, htld_pkg::CH_INTERNAL, 1'b0);
        send(htld_pkg::CMD_HDR1, 8'h00, 1'b0);
        send(htld_pkg::CMD_HDR2, 8'h01, 1'b0);
        send(htld_pkg::CMD_TREE, 8'hFF, 1'b0);

        // random streams, mostly well formed
        n_sent  = 0;
        streams = 0;
        while (n_sent < N_ITEMS) begin
            streams++;
            // output held off for a long stretch while input keeps coming
            if (streams == 3) long_hold_req = 1;
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat (3) begin
                    send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
                    n_sent++;
                end
            end else begin
                build_tree();
                len = tree_q.size();
                cut = len;
                if (kind == 1) begin
                    // broken: wrong length or truncated tree
                    case ($urandom_range(0, 2))
                        0: len = len + 1;
                        1: len = (len > 1) ? len - 1 : len + 2;
                        default: cut = $urandom_range(0, len - 1);
                    endcase
                end
                pad = 3'($urandom_range(0, 7));
                send(htld_pkg::CMD_HDR1, {pad, len[12:8]}, 1'($urandom_range(0, 1)));
                send(htld_pkg::CMD_HDR2, len[7:0], 1'($urandom_range(0, 1)));
                for (int i = 0; i < cut; i++)
                    send(htld_pkg::CMD_TREE, tree_q[i], 1'($urandom_range(0, 1)));
                n_sent += cut + 2;
                n_data = $urandom_range(1, 6);
                for (int i = 0; i < n_data; i++) begin
                    send(htld_pkg::CMD_DATA, 8'($urandom_range(0, 255)),
                         (i == n_data - 1) && ($urandom_range(0, 9) != 0));
                    n_sent++;
                end
            end
            if (streams % 25 == 0) drain_all();
        end

        drain_all();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && sym_exp_q.size() == 0) begin
            $display("PASS huffman_tree_load_and_decode_core");
        end else begin
            $display("FAIL huffman_tree_load_and_decode_core");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/htld_pkg.sv
rtl/htld_ram.sv
rtl/htld_datapath.sv
rtl/htld_ctrl.sv
rtl/huffman_tree_load_and_decode_core.sv
tb/huffman_tree_load_and_decode_core_tb.sv
